// ----- rtl/aenv_pkg.sv -----
package aenv_pkg;

  // operation codes carried in the input tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLUMNS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_FRAME = 2'd2;

  // register widths
  localparam int CC_W  = 4;
  localparam int AC_W  = 12;
  localparam int PPF_W = 32;

  // input field widths and offsets inside tdata
  localparam int FO_W   = 16;
  localparam int IDX_W  = 16;
  localparam int FS_W   = 17;
  localparam int SMP_W  = 16;
  localparam int RCOL_W = 11;
  localparam int RCH_W  = 3;
  localparam int FO_LSB   = 0;
  localparam int IDX_LSB  = FO_LSB + FO_W;
  localparam int FS_LSB   = IDX_LSB + IDX_W;
  localparam int SMP_LSB  = FS_LSB + FS_W;
  localparam int RCOL_LSB = SMP_LSB + SMP_W;
  localparam int RCH_LSB  = RCOL_LSB + RCOL_W;
  localparam int IN_TDATA_W = 80;

  // result word
  localparam int OUT_TDATA_W = 32;

  // one envelope entry as held in the store
  typedef struct packed {
    logic signed [SMP_W-1:0] pmax;
    logic signed [SMP_W-1:0] pmin;
  } env_entry_t;

  localparam env_entry_t ENTRY_ZERO = '{pmax: '0, pmin: '0};

endpackage

// ----- rtl/aenv_div.sv -----
module aenv_div #(
  parameter int N_W = 33,
  parameter int D_W = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quotient,
  output logic [D_W-1:0] remainder
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   num_r, num_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r;
  logic [D_W:0]     trial;
  logic             fits;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign trial = {rem_r, num_r[N_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[N_W-2:0], fits};
      rem_nxt = fits ? D_W'(trial - {1'b0, den_r}) : trial[D_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy      = busy_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/aenv_store.sv -----
module aenv_store #(
  parameter int ADDR_W = 14
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  aenv_pkg::env_entry_t wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output aenv_pkg::env_entry_t rdata
);
  import aenv_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  env_entry_t mem [DEPTH];
  env_entry_t rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/audio_min_max_column_envelope.sv -----
// sample word: after acceptance it passes S_MUL, S_NUM, S_DIV and S_COL, then S_WR
//   to write-back on a column hit; the serial column divider holds it longest in S_DIV
// read word: result registered in S_RDOUT once the output register is free, then waits for out_tready
// clear word: zeroes all 2^(col bits + channel bits) entries, 16384 at default size, one entry per cycle
// reset: synchronous active-low rst_n; registers go to 0, 2048, 0x10000 and a clearing
//   pass over every entry runs before the first word is taken
module audio_min_max_column_envelope #(
  parameter int MAX_COLUMNS  = 2048,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // frame_offset, sample_index, frame_samples, sample_value, read_column, read_channel
  input  logic [aenv_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op
  input  logic [aenv_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // peak_max, peak_min
  output logic [aenv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // in_range
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [aenv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aenv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import aenv_pkg::*;

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = COL_W + CH_W;
  localparam int NUM_W  = 49;
  localparam int DIVN_W = NUM_W - 16;
  localparam int SUM_W  = DIVN_W + 1;
  localparam logic [16:0] MAX_COL_L = 17'(MAX_COLUMNS);
  localparam logic [4:0]  MAX_CH_L  = 5'(MAX_CHANNELS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_NUM, S_DIV, S_COL, S_WR, S_RDOUT
  } state_t;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;

  // configuration registers
  logic [CC_W-1:0]  chan_cnt_r;
  logic [AC_W-1:0]  act_cols_r;
  logic [PPF_W-1:0] ppf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= '0;
      act_cols_r <= AC_W'(2048);
      ppf_r      <= PPF_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT:    chan_cnt_r <= cfg_wdata[CC_W-1:0];
        REG_ACTIVE_COLUMNS:   act_cols_r <= cfg_wdata[AC_W-1:0];
        REG_PIXELS_PER_FRAME: ppf_r      <= cfg_wdata[PPF_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits
  logic [CC_W-1:0] eff_ch;
  logic [16:0]     eff_cols;
  assign eff_ch   = ({1'b0, chan_cnt_r} > MAX_CH_L) ? '0 : chan_cnt_r;
  assign eff_cols = ({5'd0, act_cols_r} > MAX_COL_L) ? MAX_COL_L : {5'd0, act_cols_r};

  // input fields
  logic [OP_W-1:0]   in_op;
  logic [FO_W-1:0]   in_fo;
  logic [IDX_W-1:0]  in_idx;
  logic [FS_W-1:0]   in_fs;
  logic [SMP_W-1:0]  in_smp;
  logic [RCOL_W-1:0] in_rcol;
  logic [RCH_W-1:0]  in_rch;
  logic              in_acc;
  assign in_op   = in_tuser;
  assign in_fo   = in_tdata[FO_LSB +: FO_W];
  assign in_idx  = in_tdata[IDX_LSB +: IDX_W];
  assign in_fs   = in_tdata[FS_LSB +: FS_W];
  assign in_smp  = in_tdata[SMP_LSB +: SMP_W];
  assign in_rcol = in_tdata[RCOL_LSB +: RCOL_W];
  assign in_rch  = in_tdata[RCH_LSB +: RCH_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // held item and arithmetic pipeline registers
  logic [FO_W-1:0]          fo_r;
  logic [IDX_W-1:0]         idx_r;
  logic [FS_W-1:0]          fs_r;
  logic signed [SMP_W-1:0]  smp_r;
  logic [FO_W+PPF_W-1:0]    t1_r;
  logic [IDX_W+PPF_W-1:0]   t2_r;
  logic [PPF_W-1:0]         q1_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     oos_r;
  logic                     inr_r;
  env_entry_t               out_ent_r;
  logic                     out_inr_r;

  // read word decode
  logic [15:0]       rd_col_ext;
  logic [3:0]        rd_ch_ext;
  logic              rd_oos;
  logic              rd_inr;
  logic [ADDR_W-1:0] rd_addr;
  assign rd_col_ext = 16'(in_rcol);
  assign rd_ch_ext  = 4'(in_rch);
  assign rd_oos = ({6'd0, in_rcol} >= MAX_COL_L) || ({2'd0, in_rch} >= MAX_CH_L);
  assign rd_inr = !rd_oos && ({6'd0, in_rcol} < eff_cols) && ({1'b0, in_rch} < eff_ch);
  assign rd_addr = {rd_col_ext[COL_W-1:0], rd_ch_ext[CH_W-1:0]};

  // remainder term and divider operand
  logic [FS_W+16-1:0] r1_fs;
  logic [NUM_W-1:0]   num_w;
  logic               div_start;
  assign r1_fs     = {17'd0, t1_r[15:0]} * {16'd0, fs_r};
  assign num_w     = {16'd0, r1_fs} + {1'b0, t2_r};
  assign div_start = (state_r == S_NUM);

  logic              col_busy, ch_busy;
  logic [DIVN_W-1:0] col_quo;
  logic [FS_W-1:0]   col_rem;
  logic [IDX_W-1:0]  ch_quo;
  logic [CC_W-1:0]   ch_rem;

  aenv_div #(.N_W(DIVN_W), .D_W(FS_W)) u_col_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (num_w[NUM_W-1:16]),
    .divisor   (fs_r),
    .busy      (col_busy),
    .quotient  (col_quo),
    .remainder (col_rem)
  );

  aenv_div #(.N_W(IDX_W), .D_W(CC_W)) u_ch_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (idx_r),
    .divisor   (eff_ch),
    .busy      (ch_busy),
    .quotient  (ch_quo),
    .remainder (ch_rem)
  );

  // column and store address of a sample
  logic [SUM_W-1:0]  col_sum;
  logic              col_hit;
  logic [ADDR_W-1:0] smp_addr;
  assign col_sum  = {2'd0, q1_r} + {1'b0, col_quo};
  assign col_hit  = col_sum < {17'd0, eff_cols};
  assign smp_addr = {col_sum[COL_W-1:0], ch_rem[CH_W-1:0]};

  // store access
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  env_entry_t        mem_wdata, mem_rdata, upd_ent;

  always_comb begin
    upd_ent.pmax = (smp_r > mem_rdata.pmax) ? smp_r : mem_rdata.pmax;
    upd_ent.pmin = (smp_r < mem_rdata.pmin) ? smp_r : mem_rdata.pmin;
  end

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WR);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? ENTRY_ZERO : upd_ent;
  assign mem_re    = (in_acc && in_op == OP_READ) || (state_r == S_COL && col_hit);
  assign mem_raddr = (state_r == S_COL) ? smp_addr : rd_addr;

  aenv_store #(.ADDR_W(ADDR_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_op == OP_CLEAR) begin
            state_nxt   = S_CLEAR;
            clr_cnt_nxt = '0;
          end else if (in_op == OP_SAMPLE && eff_ch != '0) begin
            state_nxt = S_MUL;
          end else if (in_op == OP_READ) begin
            state_nxt = S_RDOUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MUL: state_nxt = S_NUM;
      S_NUM: state_nxt = S_DIV;
      S_DIV: begin
        if (!col_busy && !ch_busy) begin
          state_nxt = S_COL;
        end
      end
      S_COL: state_nxt = col_hit ? S_WR : S_IDLE;
      S_WR:  state_nxt = S_IDLE;
      S_RDOUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fo_r   <= in_fo;
      idx_r  <= in_idx;
      fs_r   <= (in_fs == '0) ? FS_W'(1) : in_fs;
      smp_r  <= in_smp;
      oos_r  <= rd_oos;
      inr_r  <= rd_inr;
    end
    if (state_r == S_MUL) begin
      t1_r <= {32'd0, fo_r} * {16'd0, ppf_r};
      t2_r <= {32'd0, idx_r} * {16'd0, ppf_r};
    end
    if (state_r == S_NUM) begin
      q1_r <= t1_r[FO_W+PPF_W-1:16];
    end
    if (state_r == S_COL) begin
      addr_r <= smp_addr;
    end
    if (state_r == S_RDOUT && (!out_tvalid_r || out_tready)) begin
      out_ent_r <= oos_r ? ENTRY_ZERO : mem_rdata;
      out_inr_r <= inr_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_ent_r.pmin, out_ent_r.pmax};
  assign out_tuser  = out_inr_r;

  // envelope always spans zero when written back
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (!mem_wdata.pmax[SMP_W-1] &&
      (mem_wdata.pmin[SMP_W-1] || mem_wdata.pmin == '0)))
    else $error("envelope entry written without zero inside");

  // column is only formed once both dividers have finished
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL) |-> (!col_busy && !ch_busy))
    else $error("column formed while a divider is busy");

  // a clear word restarts the sweep from the first entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_CLEAR) |=> (state_r == S_CLEAR && clr_cnt_r == '0))
    else $error("clear word did not start a sweep");

  // a result only appears after a read word
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_RDOUT))
    else $error("result word without a read");

endmodule
